FILE: design/lob_pkg.sv
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int BOOK_DEPTH = 16;
  localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_TRADE  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  typedef struct packed {
    logic        operation;
    logic        is_buy;
    logic [31:0] price;
    logic [30:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] buy_order_id;
    logic [31:0] sell_order_id;
    logic [31:0] trade_price;
    logic [30:0] trade_quantity;
    logic        last;
  } out_item_t;

  // one book entry
  typedef struct packed {
    logic [31:0] price;
    logic [30:0] qty;
    logic [31:0] id;
  } entry_t;

  // scan unit control from the sequencer
  typedef struct packed {
    logic             clear;   // restart best search
    logic             step;    // compare the presented entry
    logic             is_buy;  // ordering rule
    logic [IDX_W-1:0] idx;     // slot being presented
  } scan_ctl_t;

endpackage

FILE: design/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Single-symbol order book with price-time matching.
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken at
// that edge. An add holds busy while it walks its side one slot a cycle
// for the lowest free slot, and its one result shows in the first cycle
// with busy low. A match runs in rounds: in each, the shared compare unit
// walks the buy side, then the sell side, one entry a cycle, then the
// cross state crosses the two best orders. Each trade is held one round
// and leaves after the next round's cross, so the final one can carry
// last; a match with n trades holds busy for n+1 rounds, and a match that
// crosses nothing answers with one no-trade result after a single round.
// Each result is shown for one cycle under out_valid and must be taken
// then; the receiver cannot stall. The last result of an item shows in the
// first cycle with busy low, so the next item can be taken at the edge
// ending it.
module limit_order_book_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lob_pkg::in_item_t  in_item,
  output logic               out_valid,
  output lob_pkg::out_item_t out_item
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_SBUY  = 5'b00100,
    ST_SSELL = 5'b01000,
    ST_CROSS = 5'b10000
  } state_t;

  localparam int CNT_W = lob_pkg::IDX_W + 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(lob_pkg::BOOK_DEPTH);

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  lob_pkg::in_item_t           req_r, req_nxt;
  logic [31:0]                 next_id_r, next_id_nxt;
  logic [lob_pkg::BOOK_DEPTH-1:0] buy_v_r, buy_v_nxt, sell_v_r, sell_v_nxt;
  lob_pkg::entry_t             buy_e_r [lob_pkg::BOOK_DEPTH];
  lob_pkg::entry_t             sell_e_r [lob_pkg::BOOK_DEPTH];
  logic                        free_f_r, free_f_nxt;
  logic [lob_pkg::IDX_W-1:0]   free_i_r, free_i_nxt;
  logic                        bfound_r, bfound_nxt;
  logic [lob_pkg::IDX_W-1:0]   bidx_r, bidx_nxt;
  lob_pkg::entry_t             bbest_r, bbest_nxt;
  logic                        ntrade_r, ntrade_nxt;
  logic                        ov_r, ov_nxt;
  lob_pkg::out_item_t          oi_r, oi_nxt;

  // write port for one entry per cycle
  logic                        wr_en, wr_buy;
  logic [lob_pkg::IDX_W-1:0]   wr_idx;
  lob_pkg::entry_t             wr_ent;

  lob_pkg::scan_ctl_t          sc;
  logic [lob_pkg::IDX_W-1:0]   cidx;
  logic                        ent_v;
  lob_pkg::entry_t             ent;
  logic                        s_found;
  logic [lob_pkg::IDX_W-1:0]   s_idx;
  lob_pkg::entry_t             s_best;
  logic [30:0]                 q;

  assign cidx = cnt_r[lob_pkg::IDX_W-1:0];
  assign ent_v = (state_r == ST_SSELL) ? sell_v_r[cidx] : buy_v_r[cidx];
  assign ent   = (state_r == ST_SSELL) ? sell_e_r[cidx] : buy_e_r[cidx];

  lob_best_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sc),
    .ent_valid(ent_v),
    .ent      (ent),
    .found    (s_found),
    .best_idx (s_idx),
    .best     (s_best)
  );

  assign q = (bbest_r.qty < s_best.qty) ? bbest_r.qty : s_best.qty;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    next_id_nxt = next_id_r;
    buy_v_nxt   = buy_v_r;
    sell_v_nxt  = sell_v_r;
    free_f_nxt  = free_f_r;
    free_i_nxt  = free_i_r;
    bfound_nxt  = bfound_r;
    bidx_nxt    = bidx_r;
    bbest_nxt   = bbest_r;
    ntrade_nxt  = ntrade_r;
    ov_nxt      = 1'b0;
    oi_nxt      = '0;
    wr_en       = 1'b0;
    wr_buy      = 1'b0;
    wr_idx      = '0;
    wr_ent      = '0;
    sc          = '0;
    sc.idx      = cidx;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt    = in_item;
          cnt_nxt    = '0;
          free_f_nxt = 1'b0;
          ntrade_nxt = 1'b0;
          sc.clear   = 1'b1;
          state_nxt  = (in_item.operation == lob_pkg::OP_ADD) ? ST_ADD : ST_SBUY;
        end
      end
      // walk the side for the lowest free slot
      ST_ADD: begin
        if (cnt_r != LAST_CNT) begin
          if (!free_f_r && !(req_r.is_buy ? buy_v_r[cidx] : sell_v_r[cidx])) begin
            free_f_nxt = 1'b1;
            free_i_nxt = cidx;
          end
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          ov_nxt = 1'b1;
          oi_nxt.last = 1'b1;
          if (!free_f_r) begin
            oi_nxt.kind = lob_pkg::KIND_FULL;
          end else begin
            oi_nxt.kind         = lob_pkg::KIND_ACCEPT;
            oi_nxt.buy_order_id = next_id_r;
            next_id_nxt         = next_id_r + 32'd1;
            wr_en  = 1'b1;
            wr_buy = req_r.is_buy;
            wr_idx = free_i_r;
            wr_ent = '{price: req_r.price, qty: req_r.quantity, id: next_id_r};
            if (req_r.is_buy) buy_v_nxt[free_i_r] = 1'b1;
            else sell_v_nxt[free_i_r] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      // find best buy, one slot a cycle
      ST_SBUY: begin
        sc.is_buy = 1'b1;
        if (cnt_r != LAST_CNT) begin
          sc.step = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          bfound_nxt = s_found;
          bidx_nxt   = s_idx;
          bbest_nxt  = s_best;
          sc.clear   = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ST_SSELL;
        end
      end
      // find best sell
      ST_SSELL: begin
        if (cnt_r != LAST_CNT) begin
          sc.step = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_CROSS;
        end
      end
      // cross the two best orders or finish
      ST_CROSS: begin
        ov_nxt = 1'b1;
        cnt_nxt = '0;
        sc.clear = 1'b1;
        if (bfound_r && s_found && !(bbest_r.price < s_best.price)) begin
          oi_nxt.kind           = lob_pkg::KIND_TRADE;
          oi_nxt.buy_order_id   = bbest_r.id;
          oi_nxt.sell_order_id  = s_best.id;
          oi_nxt.trade_price    = s_best.price;
          oi_nxt.trade_quantity = q;
          ntrade_nxt = 1'b1;
          if (bbest_r.qty == q) buy_v_nxt[bidx_r] = 1'b0;
          if (s_best.qty == q) sell_v_nxt[s_idx] = 1'b0;
          // one port write per cycle: buy residual here, sell residual written below
          wr_en  = 1'b1;
          wr_buy = 1'b1;
          wr_idx = bidx_r;
          wr_ent = '{price: bbest_r.price, qty: bbest_r.qty - q, id: bbest_r.id};
          state_nxt = ST_SBUY;
        end else if (ntrade_r) begin
          // mark the previous trade as the final one: trades leave one
          // round later so the last flag can be set
          ov_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          oi_nxt.kind = lob_pkg::KIND_NONE;
          oi_nxt.last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // trades are held one round so last can be set on the final one
  lob_pkg::out_item_t hold_r, hold_nxt;
  logic               hv_r, hv_nxt;
  logic               pv;
  lob_pkg::out_item_t pi;

  always_comb begin
    hold_nxt = hold_r;
    hv_nxt   = hv_r;
    pv       = 1'b0;
    pi       = '0;
    if (ov_nxt && oi_nxt.kind == lob_pkg::KIND_TRADE) begin
      pv       = hv_r;
      pi       = hold_r;
      hold_nxt = oi_nxt;
      hv_nxt   = 1'b1;
    end else if (state_r == ST_CROSS && state_nxt == ST_IDLE && hv_r) begin
      pv      = 1'b1;
      pi      = hold_r;
      pi.last = 1'b1;
      hv_nxt  = 1'b0;
    end else if (ov_nxt) begin
      pv = 1'b1;
      pi = oi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      next_id_r <= 32'd1;
      buy_v_r   <= '0;
      sell_v_r  <= '0;
      free_f_r  <= 1'b0;
      bfound_r  <= 1'b0;
      ntrade_r  <= 1'b0;
      ov_r      <= 1'b0;
      hv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      next_id_r <= next_id_nxt;
      buy_v_r   <= buy_v_nxt;
      sell_v_r  <= sell_v_nxt;
      free_f_r  <= free_f_nxt;
      bfound_r  <= bfound_nxt;
      ntrade_r  <= ntrade_nxt;
      ov_r      <= pv;
      hv_r      <= hv_nxt;
    end
    req_r    <= req_nxt;
    free_i_r <= free_i_nxt;
    bidx_r   <= bidx_nxt;
    bbest_r  <= bbest_nxt;
    oi_r     <= pi;
    hold_r   <= hold_nxt;
  end

  // entry stores: port writes to either side, plus the sell residual on a cross
  always_ff @(posedge clk) begin
    if (wr_en && wr_buy) begin
      buy_e_r[wr_idx] <= wr_ent;
    end
    if (wr_en && !wr_buy) begin
      sell_e_r[wr_idx] <= wr_ent;
    end
    if (state_r == ST_CROSS && wr_en && wr_buy) begin
      sell_e_r[s_idx].qty <= s_best.qty - q;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy || $past(state_r) == ST_CROSS ||
    $past(state_r) == ST_ADD)
    else $error("last result while still working");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");
  a_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == lob_pkg::KIND_FULL |-> $stable(next_id_r))
    else $error("rejected add used an id");
`endif

endmodule

FILE: design/lob_best_scan.sv
// ----------------------------------------------------------------------------
// lob_best_scan
// Shared compare unit: folds one book entry per cycle, while step is high, into a running best.
// ----------------------------------------------------------------------------
module lob_best_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lob_pkg::scan_ctl_t        ctl,
  input  logic                      ent_valid,
  input  lob_pkg::entry_t           ent,
  output logic                      found,
  output logic [lob_pkg::IDX_W-1:0] best_idx,
  output lob_pkg::entry_t           best
);

  logic                      found_r, found_nxt;
  logic [lob_pkg::IDX_W-1:0] idx_r, idx_nxt;
  lob_pkg::entry_t           best_r, best_nxt;
  logic                      better;

  // decide whether the presented entry beats the running best
  always_comb begin
    if (!found_r) begin
      better = 1'b1;
    end else if (ctl.is_buy) begin
      better = (ent.price > best_r.price) ||
               (ent.price == best_r.price && ent.id < best_r.id);
    end else begin
      better = (ent.price < best_r.price) ||
               (ent.price == best_r.price && ent.id < best_r.id);
    end
  end

  always_comb begin
    found_nxt = found_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.step && ent_valid && better) begin
      found_nxt = 1'b1;
      idx_nxt   = ctl.idx;
      best_nxt  = ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
  end

  assign found    = found_r;
  assign best_idx = idx_r;
  assign best     = best_r;

endmodule

FILE: tb/tb_limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher
// Drives add and match items into the order book matcher, predicts every
// result with a behavioral model of the book kept in the testbench, and
// checks each whole result against the prediction in order.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  lob_pkg::in_item_t  in_item;
  logic               out_valid;
  lob_pkg::out_item_t out_item;

  // model of the book
  logic        bk_buy_vld  [lob_pkg::BOOK_DEPTH];
  logic [31:0] bk_buy_px   [lob_pkg::BOOK_DEPTH];
  logic [30:0] bk_buy_qty  [lob_pkg::BOOK_DEPTH];
  logic [31:0] bk_buy_id   [lob_pkg::BOOK_DEPTH];
  logic        bk_sell_vld [lob_pkg::BOOK_DEPTH];
  logic [31:0] bk_sell_px  [lob_pkg::BOOK_DEPTH];
  logic [30:0] bk_sell_qty [lob_pkg::BOOK_DEPTH];
  logic [31:0] bk_sell_id  [lob_pkg::BOOK_DEPTH];
  logic [31:0] bk_next_id;

  lob_pkg::out_item_t expected_results[$];
  int                 n_errors;
  int                 n_results;
  int                 n_trades;
  int                 n_items;

  limit_order_book_matcher i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Time limit: about 260 items, each with all its match rounds plus gaps,
  // stay well under this bound at worst
  initial begin
    #10000000;
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  function automatic lob_pkg::out_item_t make_result(logic [1:0] kind, logic [31:0] bid,
                                                     logic [31:0] sid, logic [31:0] px,
                                                     logic [30:0] qty, logic last);
    lob_pkg::out_item_t r;
    r.kind = kind; r.buy_order_id = bid; r.sell_order_id = sid;
    r.trade_price = px; r.trade_quantity = qty; r.last = last;
    return r;
  endfunction

  // Append one expected result at the tail
  task automatic queue_result(lob_pkg::out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic book_clear();
    for (int i = 0; i < lob_pkg::BOOK_DEPTH; i++) begin
      bk_buy_vld[i] = 1'b0;
      bk_sell_vld[i] = 1'b0;
    end
    bk_next_id = 32'd1;
  endtask

  // Predict the results of one item and update the model book
  task automatic predict_book(lob_pkg::in_item_t it);
    int          slot;
    int          b;
    int          s;
    int          n;
    logic [30:0] q;
    slot = -1;
    n = 0;
    if (it.operation == lob_pkg::OP_ADD) begin
      for (int i = lob_pkg::BOOK_DEPTH - 1; i >= 0; i--)
        if (!(it.is_buy ? bk_buy_vld[i] : bk_sell_vld[i])) slot = i;
      if (slot < 0) begin
        queue_result(make_result(lob_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1));
      end else begin
        if (it.is_buy) begin
          bk_buy_vld[slot] = 1'b1; bk_buy_px[slot] = it.price;
          bk_buy_qty[slot] = it.quantity; bk_buy_id[slot] = bk_next_id;
        end else begin
          bk_sell_vld[slot] = 1'b1; bk_sell_px[slot] = it.price;
          bk_sell_qty[slot] = it.quantity; bk_sell_id[slot] = bk_next_id;
        end
        queue_result(make_result(lob_pkg::KIND_ACCEPT, bk_next_id, '0, '0, '0, 1'b1));
        bk_next_id = bk_next_id + 32'd1;
      end
    end else begin
      forever begin
        b = -1;
        s = -1;
        for (int i = 0; i < lob_pkg::BOOK_DEPTH; i++) begin
          if (bk_buy_vld[i] && (b < 0 || bk_buy_px[i] > bk_buy_px[b] ||
              (bk_buy_px[i] == bk_buy_px[b] && bk_buy_id[i] < bk_buy_id[b]))) b = i;
          if (bk_sell_vld[i] && (s < 0 || bk_sell_px[i] < bk_sell_px[s] ||
              (bk_sell_px[i] == bk_sell_px[s] && bk_sell_id[i] < bk_sell_id[s]))) s = i;
        end
        if (b < 0 || s < 0 || bk_buy_px[b] < bk_sell_px[s]) break;
        q = (bk_buy_qty[b] < bk_sell_qty[s]) ? bk_buy_qty[b] : bk_sell_qty[s];
        queue_result(make_result(lob_pkg::KIND_TRADE, bk_buy_id[b], bk_sell_id[s],
                                 bk_sell_px[s], q, 1'b0));
        n++;
        bk_buy_qty[b] -= q;
        bk_sell_qty[s] -= q;
        if (bk_buy_qty[b] == '0) bk_buy_vld[b] = 1'b0;
        if (bk_sell_qty[s] == '0) bk_sell_vld[s] = 1'b0;
      end
      if (n == 0) begin
        queue_result(make_result(lob_pkg::KIND_NONE, '0, '0, '0, '0, 1'b1));
      end else begin
        expected_results[expected_results.size() - 1].last = 1'b1;
      end
    end
  endtask

  // Send one item after an idle gap; hold it until taken while busy is low
  task automatic send_item(logic op, logic buy, logic [31:0] px, logic [30:0] qty);
    lob_pkg::in_item_t it;
    lob_pkg::in_item_t junk;
    int                gap;
    it.operation = op; it.is_buy = buy; it.price = px; it.quantity = qty;
    junk.operation = 1'($urandom()); junk.is_buy = 1'($urandom());
    junk.price = $urandom(); junk.quantity = 31'($urandom());
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) :
          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    // start stays low for at least one edge after the previous item
    repeat (gap + 1) @(posedge clk);
    predict_book(it);
    start   <= 1'b1;
    in_item <= it;
    // busy read here is its value before the edge: taken where it was low
    @(posedge clk);
    while (busy) @(posedge clk);
    start   <= 1'b0;
    in_item <= junk;
    n_items++;
  endtask

  task automatic send_add(logic buy, logic [31:0] px, logic [30:0] qty);
    send_item(lob_pkg::OP_ADD, buy, px, qty);
  endtask

  task automatic send_match();
    send_item(lob_pkg::OP_MATCH, 1'($urandom()), $urandom(), 31'($urandom()));
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    lob_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (out_item.kind == lob_pkg::KIND_TRADE) n_trades++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
          n_errors++;
        end
      end
    end
  end

  // Empty book, zero quantity, extreme prices and quantities, trades
  task automatic test_directed();
    send_match();
    send_add(1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_match();
    send_add(1'b0, 32'h0, 31'd0);
    send_add(1'b0, 32'h0, 31'd5);
    send_add(1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_match();
    send_add(1'b1, 32'd100, 31'd10);
    send_add(1'b1, 32'd100, 31'd7);
    send_add(1'b0, 32'd90, 31'd12);
    send_add(1'b0, 32'd101, 31'd1);
    send_match();
    send_match();
  endtask

  // Fill both sides past capacity, then match the crossing orders
  task automatic test_full_side();
    for (int i = 0; i < lob_pkg::BOOK_DEPTH + 2; i++)
      send_add(1'b1, 32'd1000 + 32'(i % 3), 31'(1 + i));
    for (int i = 0; i < lob_pkg::BOOK_DEPTH + 2; i++)
      send_add(1'b0, 32'd999 + 32'(i % 4), 31'(2 + i));
    send_match();
    send_match();
  endtask

  // Random adds, mostly near a common price, with a match now and then
  task automatic test_random(int count);
    logic [31:0] px;
    logic [30:0] qty;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_match();
      end else begin
        case ($urandom_range(0, 9))
          0: px = $urandom();
          1: px = 32'hFFFF_FFFF - $urandom_range(0, 3);
          2: px = $urandom_range(0, 3);
          default: px = 32'h8000_0000 + $urandom_range(0, 20) - 10;
        endcase
        case ($urandom_range(0, 9))
          0: qty = 31'($urandom());
          1: qty = 31'h7FFF_FFFF;
          2: qty = '0;
          default: qty = 31'($urandom_range(1, 50));
        endcase
        send_add(1'($urandom_range(0, 1)), px, qty);
      end
    end
    send_match();
  endtask

  initial begin
    n_errors = 0; n_results = 0; n_trades = 0; n_items = 0;
    start   = 1'b0;
    in_item = '0;
    rst_n   = 1'b0;
    book_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_side();
    test_random(210);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * lob_pkg::BOOK_DEPTH + 10) @(posedge clk);
    $display("Sent %0d items (adds and matches), checked %0d results, %0d trades.",
             n_items, n_results, n_trades);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: limit_order_book_matcher.f
design/lob_pkg.sv
design/lob_best_scan.sv
design/limit_order_book_matcher.sv
tb/tb_limit_order_book_matcher.sv
